[rtl/ffdc_pkg.sv]
// ----------------------------------------------------------------------------
// ffdc_pkg
// Shared types, constants and the CRC byte step for the frame deframer/checker.
// ----------------------------------------------------------------------------
package ffdc_pkg;

  localparam int HEADER_BYTES    = 28;
  localparam int COUNT_LIMIT_DEF = 511;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 16;

  localparam logic [31:0] CRC_POLY = 32'hedb88320;
  localparam logic [31:0] CRC_ONES = 32'hffffffff;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_FRAME_LEN    = 3'd0,
    REG_PAYLOAD_CAPACITY = 3'd1,
    REG_MAGIC_WORD       = 3'd2,
    REG_CONTROL_EXPECTED = 3'd3,
    REG_MIN_TOTAL_LENGTH = 3'd4,
    REG_MAX_TOTAL_LENGTH = 3'd5,
    REG_MAX_FRAGMENTS    = 3'd6,
    REG_MAX_PAYLOAD_LEN  = 3'd7
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_OK           = 4'd0,
    ST_SHORT        = 4'd1,
    ST_LARGE        = 4'd2,
    ST_MAGIC        = 4'd3,
    ST_VERSION      = 4'd4,
    ST_TYPE         = 4'd5,
    ST_LENGTH       = 4'd6,
    ST_CRC          = 4'd7,
    ST_SEQ          = 4'd8,
    ST_TOTAL        = 4'd9,
    ST_FRAGMENT     = 4'd10,
    ST_NONCANONICAL = 4'd11
  } status_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       end_of_datagram;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        payload_valid;
    logic        frame_done;
    logic [3:0]  status;
    logic [63:0] tag_value;
    logic [63:0] sender_seq;
    logic [7:0]  frag_index;
    logic [7:0]  frag_count;
    logic [15:0] message_length;
    logic [7:0]  payload_len;
  } out_item_t;

  typedef struct packed {
    logic take;
    logic load_pay;
    logic calc;
    logic load_fin;
  } dp_cmd_t;

  typedef struct packed {
    logic is_payload;
  } dp_stat_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

endpackage

[rtl/fragment_frame_deframer_checker_core.sv]
// ----------------------------------------------------------------------------
// fragment_frame_deframer_checker_core
// Byte-serial deframer and CRC-32 checker for fragmented data frames.
// ----------------------------------------------------------------------------
// Takes one datagram byte per cycle while the output register is free.
// Payload bytes (offset 28 on) come out in the cycle after through the
// output register, the last one on the status item. The end-marked item
// is followed by the S_CHK step (fragment-size products) and the S_FIN
// step (status compare chain, status item load); no input then. The user
// must write configuration via cfg_we/cfg_index/cfg_data while idle; unenforced.
module fragment_frame_deframer_checker_core #(
  parameter int COUNT_LIMIT = ffdc_pkg::COUNT_LIMIT_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [ffdc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ffdc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  ffdc_pkg::in_item_t              in_item,
  output logic                            out_valid,
  input  logic                            out_ready,
  output ffdc_pkg::out_item_t             out_item
);

  ffdc_pkg::dp_cmd_t  cmd;
  ffdc_pkg::dp_stat_t stat;

  ffdc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_last   (in_item.end_of_datagram),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ffdc_datapath #(.COUNT_LIMIT(COUNT_LIMIT)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_item   (in_item),
    .cmd       (cmd),
    .stat      (stat),
    .out_item  (out_item)
  );

endmodule

[rtl/ffdc_ctrl.sv]
// ----------------------------------------------------------------------------
// ffdc_ctrl
// Sequencer: byte intake, end-of-frame check steps and output register valid.
// ----------------------------------------------------------------------------
module ffdc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_last,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  ffdc_pkg::dp_stat_t stat,
  output ffdc_pkg::dp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_RUN = 3'b001,
    S_CHK = 3'b010,
    S_FIN = 3'b100
  } state_t;

  state_t state, state_next;
  logic   out_free;
  logic   out_valid_next;

  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state)
      S_RUN: begin
        in_ready = out_free;
        cmd.take = in_valid && out_free;
        if (cmd.take) begin
          cmd.load_pay = stat.is_payload && !in_last;
          if (in_last) state_next = S_CHK;
        end
      end
      S_CHK: begin
        cmd.calc   = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          cmd.load_fin = 1'b1;
          state_next   = S_RUN;
        end
      end
      default: state_next = S_RUN;
    endcase
  end

  assign out_valid_next = (out_valid && !out_ready) || cmd.load_pay || cmd.load_fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_RUN;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  a_ready_run: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == S_RUN) else $error("ready outside run");
  a_last_chk: assert property (@(posedge clk) disable iff (rst)
    (cmd.take && in_last) |=> state == S_CHK) else $error("last byte not checked");
  a_chk_fin: assert property (@(posedge clk) disable iff (rst)
    state == S_CHK |=> state == S_FIN) else $error("check step skipped");
  a_fin_out: assert property (@(posedge clk) disable iff (rst)
    cmd.load_fin |=> out_valid) else $error("status item lost");

endmodule

[rtl/ffdc_datapath.sv]
// ----------------------------------------------------------------------------
// ffdc_datapath
// Config registers, header capture, CRC, frame checks and output register.
// ----------------------------------------------------------------------------
module ffdc_datapath #(
  parameter int COUNT_LIMIT = ffdc_pkg::COUNT_LIMIT_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [ffdc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ffdc_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  ffdc_pkg::in_item_t                in_item,
  input  ffdc_pkg::dp_cmd_t                 cmd,
  output ffdc_pkg::dp_stat_t                stat,
  output ffdc_pkg::out_item_t               out_item
);

  localparam int             CW    = $clog2(COUNT_LIMIT + 1);
  localparam logic [CW-1:0]  LIMIT = CW'(COUNT_LIMIT);
  localparam logic [CW-1:0]  HB    = CW'(ffdc_pkg::HEADER_BYTES);

  logic [8:0]  max_frame_len;
  logic [7:0]  payload_capacity;
  logic [15:0] magic_word;
  logic [7:0]  control_expected;
  logic [15:0] min_total_length;
  logic [15:0] max_total_length;
  logic [7:0]  max_fragments;
  logic [7:0]  max_payload_len;

  logic [CW-1:0] byte_count;
  logic [31:0]   crc_reg;
  logic [15:0]   magic_seen;
  logic [7:0]    control_seen;
  logic [63:0]   tag_reg;
  logic [63:0]   seq_reg;
  logic [7:0]    index_reg;
  logic [7:0]    count_reg;
  logic [15:0]   total_reg;
  logic [7:0]    length_reg;
  logic [31:0]   rx_crc_reg;

  logic [7:0]  last_byte;
  logic        last_pay;
  logic [15:0] prod_hi;
  logic [15:0] prod_lo;

  logic [CW-1:0]    pos;
  logic [7:0]       b;
  logic             is_pay;
  ffdc_pkg::status_t status;
  logic [15:0]      exp_len;
  ffdc_pkg::out_item_t pay_item;

  assign pos             = byte_count;
  assign b               = in_item.rx_byte;
  assign is_pay          = pos >= HB;
  assign stat.is_payload = is_pay;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_frame_len    <= 9'd255;
      payload_capacity <= 8'd227;
      magic_word       <= 16'd0;
      control_expected <= 8'd16;
      min_total_length <= 16'd1;
      max_total_length <= 16'hffff;
      max_fragments    <= 8'd255;
      max_payload_len  <= 8'd255;
    end else if (cfg_we) begin
      unique case (ffdc_pkg::cfg_reg_t'(cfg_index))
        ffdc_pkg::REG_MAX_FRAME_LEN:    max_frame_len    <= cfg_data[8:0];
        ffdc_pkg::REG_PAYLOAD_CAPACITY: payload_capacity <= cfg_data[7:0];
        ffdc_pkg::REG_MAGIC_WORD:       magic_word       <= cfg_data;
        ffdc_pkg::REG_CONTROL_EXPECTED: control_expected <= cfg_data[7:0];
        ffdc_pkg::REG_MIN_TOTAL_LENGTH: min_total_length <= cfg_data;
        ffdc_pkg::REG_MAX_TOTAL_LENGTH: max_total_length <= cfg_data;
        ffdc_pkg::REG_MAX_FRAGMENTS:    max_fragments    <= cfg_data[7:0];
        ffdc_pkg::REG_MAX_PAYLOAD_LEN:  max_payload_len  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.load_fin) begin
      byte_count   <= '0;
      crc_reg      <= ffdc_pkg::CRC_ONES;
      magic_seen   <= '0;
      control_seen <= '0;
      tag_reg      <= '0;
      seq_reg      <= '0;
      index_reg    <= '0;
      count_reg    <= '0;
      total_reg    <= '0;
      length_reg   <= '0;
      rx_crc_reg   <= '0;
    end else if (cmd.take) begin
      if (pos < CW'(24) || is_pay) crc_reg <= ffdc_pkg::crc_byte(crc_reg, b);
      if (pos < CW'(2))       magic_seen   <= {magic_seen[7:0], b};
      else if (pos == CW'(2)) control_seen <= b;
      else if (pos < CW'(11)) tag_reg      <= {tag_reg[55:0], b};
      else if (pos < CW'(19)) seq_reg      <= {seq_reg[55:0], b};
      else if (pos == CW'(19)) index_reg   <= b;
      else if (pos == CW'(20)) count_reg   <= b;
      else if (pos < CW'(23)) total_reg    <= {total_reg[7:0], b};
      else if (pos == CW'(23)) length_reg  <= b;
      else if (pos < HB)      rx_crc_reg   <= {rx_crc_reg[23:0], b};
      if (byte_count < LIMIT) byte_count <= byte_count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      last_byte <= b;
      last_pay  <= is_pay;
    end
    if (cmd.calc) begin
      prod_hi <= {8'd0, payload_capacity} * {8'd0, count_reg};
      prod_lo <= {8'd0, payload_capacity} * {8'd0, count_reg - 8'd1};
    end
  end

  // fragment sizes: count = ceil(total/cap) <=> cap*(count-1) < total <= cap*count
  assign exp_len = ({1'b0, index_reg} + 9'd1 < {1'b0, count_reg}) ?
                   {8'd0, payload_capacity} : total_reg - prod_lo;

  always_comb begin
    if (byte_count < CW'(ffdc_pkg::HEADER_BYTES + 1))
      status = ffdc_pkg::ST_SHORT;
    else if ((CW+1)'(byte_count) > (CW+1)'(max_frame_len))
      status = ffdc_pkg::ST_LARGE;
    else if (magic_seen != magic_word)
      status = ffdc_pkg::ST_MAGIC;
    else if (control_seen[7:4] != control_expected[7:4])
      status = ffdc_pkg::ST_VERSION;
    else if (control_seen[3:0] != control_expected[3:0])
      status = ffdc_pkg::ST_TYPE;
    else if (length_reg == 8'd0 ||
             (CW+1)'(byte_count) != (CW+1)'(HB) + (CW+1)'(length_reg))
      status = ffdc_pkg::ST_LENGTH;
    else if (rx_crc_reg != ~crc_reg)
      status = ffdc_pkg::ST_CRC;
    else if (seq_reg == 64'd0)
      status = ffdc_pkg::ST_SEQ;
    else if (total_reg < min_total_length || total_reg > max_total_length)
      status = ffdc_pkg::ST_TOTAL;
    else if (count_reg == 8'd0 || count_reg > max_fragments || index_reg >= count_reg ||
             length_reg > max_payload_len)
      status = ffdc_pkg::ST_FRAGMENT;
    else if (payload_capacity == 8'd0 || total_reg == 16'd0 || prod_lo >= total_reg ||
             total_reg > prod_hi || {8'd0, length_reg} != exp_len)
      status = ffdc_pkg::ST_NONCANONICAL;
    else
      status = ffdc_pkg::ST_OK;
  end

  always_comb begin
    pay_item               = '0;
    pay_item.payload_byte  = b;
    pay_item.payload_valid = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_pay) begin
      out_item <= pay_item;
    end else if (cmd.load_fin) begin
      out_item.payload_byte   <= last_pay ? last_byte : 8'd0;
      out_item.payload_valid  <= last_pay;
      out_item.frame_done     <= 1'b1;
      out_item.status         <= status;
      out_item.tag_value      <= tag_reg;
      out_item.sender_seq     <= seq_reg;
      out_item.frag_index     <= index_reg;
      out_item.frag_count     <= count_reg;
      out_item.message_length <= total_reg;
      out_item.payload_len    <= length_reg;
    end
  end

endmodule
